// File: hw/rtl/psd_pkg.sv
// ============================================================================
// psd_pkg: shared types and constants of the publish/subscribe dispatcher
// Sizes of the topic space, subscriber slots and pending queue, the opcode
// and status codes, and the structs that pass between the submodules.
// ============================================================================
package psd_pkg;

   // sizes
   localparam int TOPIC_BITS  = 10;
   localparam int SLOTS       = 8;
   localparam int QUEUE_DEPTH = 16;
   localparam int ID_BITS     = 8;
   localparam int DATA_BITS   = 32;
   localparam int OP_BITS     = 2;
   localparam int STATUS_BITS = 3;
   localparam int NUM_TOPICS  = 1 << TOPIC_BITS;
   localparam int QPTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

   // request opcodes; the fourth code is unused
   typedef enum logic [OP_BITS-1:0] {
      OP_SUB = 2'd0,
      OP_PUB = 2'd1,
      OP_DSP = 2'd2
   } psd_op_type;

   // result status codes
   typedef enum logic [STATUS_BITS-1:0] {
      ST_OK      = 3'd0,
      ST_QFULL   = 3'd1,
      ST_QEMPTY  = 3'd2,
      ST_TFULL   = 3'd3,
      ST_ALREADY = 3'd4,
      ST_NOSUB   = 3'd5
   } psd_status_type;

   // one subscriber table row: SLOTS ids, zero marks an empty slot
   typedef logic [SLOTS-1:0][ID_BITS-1:0] psd_row_type;

   // subscriber table write request
   typedef struct packed {
      logic                  en;
      logic [TOPIC_BITS-1:0] addr;
      psd_row_type           row;
   } psd_slot_wr_type;

   // pending queue control and status
   typedef struct packed {
      logic                  push;
      logic                  pop;
      logic [TOPIC_BITS-1:0] topic;
   } psd_qctl_type;

   typedef struct packed {
      logic full;
      logic empty;
   } psd_qstat_type;

   // isolate the lowest set bit of a slot mask
   function automatic logic [SLOTS-1:0] lowest_one(input logic [SLOTS-1:0] x);
      return x & (~x + SLOTS'(1));
   endfunction

endpackage

// File: hw/rtl/psd_if.sv
// ============================================================================
// psd_if: valid/ready channels of the publish/subscribe dispatcher
// Request channel (opcode, topic, subscriber, payload) and result channel
// (status, target, out_topic, out_data, last).
// ============================================================================
interface psd_req_if;
   logic                            valid;
   logic                            ready;
   logic [psd_pkg::OP_BITS-1:0]     opcode;
   logic [psd_pkg::TOPIC_BITS-1:0]  topic;
   logic [psd_pkg::ID_BITS-1:0]     subscriber;
   logic [psd_pkg::DATA_BITS-1:0]   payload;

   modport source (output valid, opcode, topic, subscriber, payload, input ready);
   modport sink   (input valid, opcode, topic, subscriber, payload, output ready);
endinterface

interface psd_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [psd_pkg::STATUS_BITS-1:0] status;
   logic [psd_pkg::ID_BITS-1:0]     target;
   logic [psd_pkg::TOPIC_BITS-1:0]  out_topic;
   logic [psd_pkg::DATA_BITS-1:0]   out_data;
   logic                            last;

   modport source (output valid, status, target, out_topic, out_data, last, input ready);
   modport sink   (input valid, status, target, out_topic, out_data, last, output ready);
endinterface

// File: hw/rtl/publish_subscribe_dispatcher.sv
// ============================================================================
// publish_subscribe_dispatcher: topic broker with subscriber table and queue
// Subscribes ids to topics, stores published data and queues topics, and
// delivers the head topic to every subscriber on dispatch.
// ============================================================================
// Usage
//   req_ch carries one operation per transfer: subscribe, publish or
//   dispatch. rsp_ch returns the results; subscribe and publish give one,
//   dispatch gives one per occupied slot in slot order (last marks the
//   final one) or a single queue-empty or no-subscriber result. The fourth
//   opcode is taken and gives no result.
//   Items are handled one at a time. The table, data and queue memories
//   have registered reads (read, then modify and write back), and one
//   result register issues one transfer per cycle while rsp_ch is ready.
//   A new request is taken while the last result still waits in the output
//   register; a stalled rsp_ch holds the block in the state that owns the
//   next result, with all memories untouched.
//   Reset empties the queue and starts a clearing pass over all 1024 rows
//   of the subscriber table (one row per cycle); req_ch.ready stays low
//   until it ends.
// ============================================================================
module publish_subscribe_dispatcher (
   input logic      clock,
   input logic      reset,
   psd_req_if.sink  req_ch,
   psd_rsp_if.source rsp_ch
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_SUB,
      S_ONE,
      S_DQ,
      S_LD,
      S_OUT
   } state_type;

   state_type                        state_ff;
   logic [psd_pkg::TOPIC_BITS-1:0]   topic_ff;
   logic [psd_pkg::ID_BITS-1:0]      id_ff;
   logic [psd_pkg::DATA_BITS-1:0]    data_ff;
   psd_pkg::psd_status_type          res_status_ff;
   psd_pkg::psd_row_type             row_ff;
   logic [psd_pkg::SLOTS-1:0]        mask_ff;

   logic                             rsp_valid_ff;
   psd_pkg::psd_status_type          rsp_status_ff;
   logic [psd_pkg::ID_BITS-1:0]      rsp_target_ff;
   logic [psd_pkg::TOPIC_BITS-1:0]   rsp_topic_ff;
   logic [psd_pkg::DATA_BITS-1:0]    rsp_data_ff;
   logic                             rsp_last_ff;

   logic                             accept;
   psd_pkg::psd_op_type              req_op;
   logic                             out_free;
   logic                             rsp_load;

   logic                             slot_rd_en;
   logic [psd_pkg::TOPIC_BITS-1:0]   slot_rd_addr;
   psd_pkg::psd_row_type             slot_rd_row;
   psd_pkg::psd_slot_wr_type         slot_wr;
   logic                             slot_busy;

   logic [psd_pkg::DATA_BITS-1:0]    data_rd;
   psd_pkg::psd_qctl_type            qctl;
   psd_pkg::psd_qstat_type           qstat;
   logic [psd_pkg::TOPIC_BITS-1:0]   q_head;

   logic [psd_pkg::SLOTS-1:0]        match_vec;
   logic [psd_pkg::SLOTS-1:0]        empty_vec;
   logic [psd_pkg::SLOTS-1:0]        fill_vec;
   logic [psd_pkg::SLOTS-1:0]        occ_vec;
   psd_pkg::psd_row_type             new_row;
   logic [psd_pkg::SLOTS-1:0]        pick;
   logic [psd_pkg::ID_BITS-1:0]      pick_id;
   logic                             pick_last;

   // handshake
   assign req_ch.ready = (state_ff == S_IDLE) && !slot_busy;
   assign accept       = req_ch.valid && req_ch.ready;
   assign req_op       = psd_pkg::psd_op_type'(req_ch.opcode);
   assign out_free     = !rsp_valid_ff || rsp_ch.ready;

   // result register loads in a result state once the output is free
   assign rsp_load = out_free && ((state_ff == S_SUB) || (state_ff == S_ONE) ||
                                  (state_ff == S_OUT));

   // memory read ports: request topic on subscribe, queue head on dispatch
   assign slot_rd_en   = (accept && (req_op == psd_pkg::OP_SUB)) || (state_ff == S_DQ);
   assign slot_rd_addr = (state_ff == S_DQ) ? q_head : req_ch.topic;

   // queue control
   assign qctl.push  = accept && (req_op == psd_pkg::OP_PUB) && !qstat.full;
   assign qctl.pop   = accept && (req_op == psd_pkg::OP_DSP) && !qstat.empty;
   assign qctl.topic = req_ch.topic;

   // subscribe: match, empty-slot search and updated row
   always_comb begin
      for (int i = 0; i < psd_pkg::SLOTS; i++) begin
         match_vec[i] = (slot_rd_row[i] == id_ff);
         empty_vec[i] = (slot_rd_row[i] == '0);
         occ_vec[i]   = !empty_vec[i];
      end
      fill_vec = psd_pkg::lowest_one(empty_vec);
      for (int i = 0; i < psd_pkg::SLOTS; i++) begin
         new_row[i] = fill_vec[i] ? id_ff : slot_rd_row[i];
      end
   end

   // write back only when a slot was filled
   assign slot_wr.en   = (state_ff == S_SUB) && out_free && !(|match_vec) && (|empty_vec);
   assign slot_wr.addr = topic_ff;
   assign slot_wr.row  = new_row;

   // dispatch: next occupied slot
   always_comb begin
      pick    = psd_pkg::lowest_one(mask_ff);
      pick_id = '0;
      for (int i = 0; i < psd_pkg::SLOTS; i++) begin
         pick_id = pick_id | (pick[i] ? row_ff[i] : '0);
      end
      pick_last = ((mask_ff & ~pick) == '0);
   end

   psd_slot_mem u_slot_mem (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (slot_rd_en),
      .rd_addr (slot_rd_addr),
      .rd_row  (slot_rd_row),
      .wr      (slot_wr),
      .busy    (slot_busy)
   );

   psd_data_mem u_data_mem (
      .clock   (clock),
      .wr_en   (accept && (req_op == psd_pkg::OP_PUB)),
      .wr_addr (req_ch.topic),
      .wr_data (req_ch.payload),
      .rd_en   (state_ff == S_DQ),
      .rd_addr (q_head),
      .rd_data (data_rd)
   );

   psd_queue u_queue (
      .clock (clock),
      .reset (reset),
      .ctl   (qctl),
      .stat  (qstat),
      .head  (q_head)
   );

   // sequencer and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_ch.ready && !rsp_load) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  topic_ff <= req_ch.topic;
                  id_ff    <= req_ch.subscriber;
                  unique case (req_op)
                     psd_pkg::OP_SUB: begin
                        state_ff <= S_SUB;
                     end
                     psd_pkg::OP_PUB: begin
                        res_status_ff <= qstat.full ? psd_pkg::ST_QFULL : psd_pkg::ST_OK;
                        data_ff       <= '0;
                        state_ff      <= S_ONE;
                     end
                     psd_pkg::OP_DSP: begin
                        if (qstat.empty) begin
                           res_status_ff <= psd_pkg::ST_QEMPTY;
                           topic_ff      <= '0;
                           data_ff       <= '0;
                           state_ff      <= S_ONE;
                        end else begin
                           state_ff <= S_DQ;
                        end
                     end
                     default: begin
                        state_ff <= S_IDLE;
                     end
                  endcase
               end
            end
            S_SUB: begin
               if (out_free) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_status_ff <= (|match_vec) ? psd_pkg::ST_ALREADY :
                                   (|empty_vec) ? psd_pkg::ST_OK : psd_pkg::ST_TFULL;
                  rsp_target_ff <= '0;
                  rsp_topic_ff  <= topic_ff;
                  rsp_data_ff   <= '0;
                  rsp_last_ff   <= 1'b1;
                  state_ff      <= S_IDLE;
               end
            end
            S_ONE: begin
               if (out_free) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_status_ff <= res_status_ff;
                  rsp_target_ff <= '0;
                  rsp_topic_ff  <= topic_ff;
                  rsp_data_ff   <= data_ff;
                  rsp_last_ff   <= 1'b1;
                  state_ff      <= S_IDLE;
               end
            end
            S_DQ: begin
               // head topic is out of the queue; table and data reads issued
               topic_ff <= q_head;
               state_ff <= S_LD;
            end
            S_LD: begin
               row_ff  <= slot_rd_row;
               mask_ff <= occ_vec;
               data_ff <= data_rd;
               if (occ_vec == '0) begin
                  res_status_ff <= psd_pkg::ST_NOSUB;
                  state_ff      <= S_ONE;
               end else begin
                  state_ff <= S_OUT;
               end
            end
            S_OUT: begin
               if (out_free) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_status_ff <= psd_pkg::ST_OK;
                  rsp_target_ff <= pick_id;
                  rsp_topic_ff  <= topic_ff;
                  rsp_data_ff   <= data_ff;
                  rsp_last_ff   <= pick_last;
                  mask_ff       <= mask_ff & ~pick;
                  if (pick_last) begin
                     state_ff <= S_IDLE;
                  end
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.status    = rsp_status_ff;
   assign rsp_ch.target    = rsp_target_ff;
   assign rsp_ch.out_topic = rsp_topic_ff;
   assign rsp_ch.out_data  = rsp_data_ff;
   assign rsp_ch.last      = rsp_last_ff;

   // a delivery always names a subscriber and reports ok
   a_delivery: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_OUT && out_free) |=>
         (rsp_ch.valid && rsp_ch.target != '0 && rsp_ch.status == psd_pkg::ST_OK))
      else $error("dispatch delivery without subscriber or with bad status");

   // only deliveries can be followed by more results
   a_not_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && !rsp_ch.last) |-> (rsp_ch.status == psd_pkg::ST_OK))
      else $error("non-final result carries an error status");

   // dispatch on an empty queue leaves the queue alone
   a_empty_dsp: assert property (@(posedge clock) disable iff (reset)
      (accept && req_op == psd_pkg::OP_DSP && qstat.empty) |-> (!qctl.pop && !qctl.push))
      else $error("queue touched by dispatch on empty queue");

   // the table is never written back during the clearing pass
   a_no_wr_clear: assert property (@(posedge clock) disable iff (reset)
      slot_wr.en |-> !slot_busy)
      else $error("subscriber table written during clearing pass");

endmodule

// File: hw/rtl/psd_slot_mem.sv
// ============================================================================
// psd_slot_mem: subscriber table memory
// One row of SLOTS ids per topic, one read and one write port, registered
// read data. After reset a clearing pass zeroes every row, one per cycle.
// ============================================================================
module psd_slot_mem (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           rd_en,
   input  logic [psd_pkg::TOPIC_BITS-1:0] rd_addr,
   output psd_pkg::psd_row_type           rd_row,
   input  psd_pkg::psd_slot_wr_type       wr,
   output logic                           busy
);

   psd_pkg::psd_row_type            mem [psd_pkg::NUM_TOPICS];
   psd_pkg::psd_row_type            rd_row_ff;
   logic                            clr_busy_ff;
   logic [psd_pkg::TOPIC_BITS-1:0]  clr_addr_ff;

   // clearing pass sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else if (clr_busy_ff) begin
         clr_addr_ff <= clr_addr_ff + psd_pkg::TOPIC_BITS'(1);
         if (clr_addr_ff == '1) begin
            clr_busy_ff <= 1'b0;
         end
      end
   end

   // write port: clearing pass has priority
   always_ff @(posedge clock) begin
      if (clr_busy_ff) begin
         mem[clr_addr_ff] <= '0;
      end else if (wr.en) begin
         mem[wr.addr] <= wr.row;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_row_ff <= mem[rd_addr];
      end
   end

   assign rd_row = rd_row_ff;
   assign busy   = clr_busy_ff;

endmodule

// File: hw/rtl/psd_data_mem.sv
// ============================================================================
// psd_data_mem: per-topic data word store
// One write port for publishes, one read port with registered data for
// dispatches. Contents are undefined until a topic is published.
// ============================================================================
module psd_data_mem (
   input  logic                           clock,
   input  logic                           wr_en,
   input  logic [psd_pkg::TOPIC_BITS-1:0] wr_addr,
   input  logic [psd_pkg::DATA_BITS-1:0]  wr_data,
   input  logic                           rd_en,
   input  logic [psd_pkg::TOPIC_BITS-1:0] rd_addr,
   output logic [psd_pkg::DATA_BITS-1:0]  rd_data
);

   logic [psd_pkg::DATA_BITS-1:0] mem [psd_pkg::NUM_TOPICS];
   logic [psd_pkg::DATA_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hw/rtl/psd_queue.sv
// ============================================================================
// psd_queue: ring queue of published topics
// Read and write pointers with an occupancy count over a small memory.
// A pop registers the head entry, valid on the following cycle.
// ============================================================================
module psd_queue (
   input  logic                           clock,
   input  logic                           reset,
   input  psd_pkg::psd_qctl_type          ctl,
   output psd_pkg::psd_qstat_type         stat,
   output logic [psd_pkg::TOPIC_BITS-1:0] head
);

   logic [psd_pkg::TOPIC_BITS-1:0] mem [psd_pkg::QUEUE_DEPTH];
   logic [psd_pkg::TOPIC_BITS-1:0] head_ff;
   logic [psd_pkg::QPTR_BITS-1:0]  rd_ptr_ff;
   logic [psd_pkg::QPTR_BITS-1:0]  wr_ptr_ff;
   logic [psd_pkg::QCNT_BITS-1:0]  count_ff;

   // ring increment, wraps at the last entry
   function automatic logic [psd_pkg::QPTR_BITS-1:0] ring_next(
      input logic [psd_pkg::QPTR_BITS-1:0] p);
      if (p == psd_pkg::QPTR_BITS'(psd_pkg::QUEUE_DEPTH - 1)) begin
         return '0;
      end
      return p + psd_pkg::QPTR_BITS'(1);
   endfunction

   // pointers and occupancy
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= '0;
         wr_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (ctl.push) begin
            wr_ptr_ff <= ring_next(wr_ptr_ff);
         end
         if (ctl.pop) begin
            rd_ptr_ff <= ring_next(rd_ptr_ff);
         end
         if (ctl.push && !ctl.pop) begin
            count_ff <= count_ff + psd_pkg::QCNT_BITS'(1);
         end else if (ctl.pop && !ctl.push) begin
            count_ff <= count_ff - psd_pkg::QCNT_BITS'(1);
         end
      end
   end

   // entry storage and registered head read
   always_ff @(posedge clock) begin
      if (ctl.push) begin
         mem[wr_ptr_ff] <= ctl.topic;
      end
      if (ctl.pop) begin
         head_ff <= mem[rd_ptr_ff];
      end
   end

   assign stat.full  = (count_ff == psd_pkg::QCNT_BITS'(psd_pkg::QUEUE_DEPTH));
   assign stat.empty = (count_ff == '0);
   assign head       = head_ff;

endmodule
